// ----- rtl/core/tcbst_pkg.sv -----
// shared types, codes and helpers for the tcb spline tangent block
package tcbst_pkg;

  // one key as held in the window
  typedef struct packed {
    logic [15:0]      frame;
    logic [2:0][31:0] pos;
    logic [2:0][15:0] tcb;
  } key_t;

  // job list bits, also the job codes of the back end
  localparam logic [2:0] J_SH0   = 3'd0;  // short track, own key alone
  localparam logic [2:0] J_SH1   = 3'd1;  // short track, first of two
  localparam logic [2:0] J_SH2   = 3'd2;  // short track, second of two
  localparam logic [2:0] J_FIRST = 3'd3;  // first key end tangent
  localparam logic [2:0] J_MID   = 3'd4;  // interior key
  localparam logic [2:0] J_FIN   = 3'd5;  // last key end tangent
  localparam int         NJOB    = 6;

  // one queued command: the window at the key plus the jobs it causes
  typedef struct packed {
    key_t            p;
    key_t            k;
    key_t            c;
    logic [NJOB-1:0] pend;
  } cmd_t;

  localparam logic signed [17:0] Q14_ONE = 18'sd16384;
  localparam logic signed [79:0] TAN_MAX = 80'sd549755813887;
  localparam logic signed [79:0] TAN_MIN = -80'sd549755813888;

  // saturate to the 40 bit tangent range
  function automatic logic signed [39:0] sat40(input logic signed [79:0] v);
    logic signed [39:0] r;
    if (v > TAN_MAX) begin
      r = TAN_MAX[39:0];
    end else if (v < TAN_MIN) begin
      r = TAN_MIN[39:0];
    end else begin
      r = v[39:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/tcbst_front.sv -----
// front end: key window, track position and job classification
module tcbst_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [15:0]          in_frame_number,
  input  logic signed [31:0]   in_pos_x,
  input  logic signed [31:0]   in_pos_y,
  input  logic signed [31:0]   in_pos_z,
  input  logic signed [15:0]   in_tension,
  input  logic signed [15:0]   in_continuity,
  input  logic signed [15:0]   in_bias,
  input  logic                 in_last_key,
  input  logic                 q_full,
  output logic                 q_push,
  output tcbst_pkg::cmd_t      q_data
);
  import tcbst_pkg::*;

  logic [1:0] cnt_r, cnt_nxt;
  key_t       old_r, mid_r;
  key_t       cur;
  logic       acc;

  // clamp a q1.14 parameter to -1..1
  function automatic logic [15:0] clamp14(input logic signed [15:0] v);
    logic [15:0] r;
    if (v > 16'sd16384) begin
      r = 16'd16384;
    end else if (v < -16'sd16384) begin
      r = 16'hC000;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // incoming key
  always_comb begin
    cur.frame  = in_frame_number;
    cur.pos[0] = in_pos_x;
    cur.pos[1] = in_pos_y;
    cur.pos[2] = in_pos_z;
    cur.tcb[0] = clamp14(in_tension);
    cur.tcb[1] = clamp14(in_continuity);
    cur.tcb[2] = clamp14(in_bias);
  end

  assign in_stall = q_full;
  assign acc      = in_valid && !q_full;

  // jobs caused by this key
  always_comb begin
    q_data.p    = old_r;
    q_data.k    = mid_r;
    q_data.c    = cur;
    q_data.pend = '0;
    case (cnt_r)
      2'd0: q_data.pend[J_SH0] = in_last_key;
      2'd1: begin
        q_data.pend[J_SH1] = in_last_key;
        q_data.pend[J_SH2] = in_last_key;
      end
      2'd2: begin
        q_data.pend[J_FIRST] = 1'b1;
        q_data.pend[J_MID]   = 1'b1;
        q_data.pend[J_FIN]   = in_last_key;
      end
      default: begin
        q_data.pend[J_MID] = 1'b1;
        q_data.pend[J_FIN] = in_last_key;
      end
    endcase
    q_push = acc && (in_last_key || cnt_r[1]);
  end

  // key count, saturating at three or more
  always_comb begin
    cnt_nxt = cnt_r;
    if (acc) begin
      if (in_last_key) begin
        cnt_nxt = 2'd0;
      end else if (cnt_r != 2'd3) begin
        cnt_nxt = cnt_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // window shift
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      old_r <= '0;
      mid_r <= '0;
    end else if (acc && !in_last_key) begin
      old_r <= mid_r;
      mid_r <= cur;
    end
  end

endmodule

// ----- rtl/core/tcbst_queue.sv -----
// two entry command queue between front and back
module tcbst_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  tcbst_pkg::cmd_t wr_data,
  output logic            full,
  input  logic            pop,
  output tcbst_pkg::cmd_t rd_data,
  output logic            empty
);
  import tcbst_pkg::*;

  cmd_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full    = cnt_r == 2'd2;
  assign empty   = cnt_r == 2'd0;
  assign rd_data = mem_r[rp_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  // pointers and fill
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

endmodule

// ----- rtl/core/tcbst_back.sv -----
// back end: tangent sequencer with shared multiplier, serial divider, result register
module tcbst_back (
  input  logic                clk,
  input  logic                rst_n,
  input  tcbst_pkg::cmd_t     q_data,
  input  logic                q_empty,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [15:0]         out_key_frame,
  output logic signed [31:0]  out_x,
  output logic signed [31:0]  out_y,
  output logic signed [31:0]  out_z,
  output logic signed [39:0]  out_in_tan_x,
  output logic signed [39:0]  out_in_tan_y,
  output logic signed [39:0]  out_in_tan_z,
  output logic signed [39:0]  out_out_tan_x,
  output logic signed [39:0]  out_out_tan_y,
  output logic signed [39:0]  out_out_tan_z,
  output logic                out_short_track,
  output logic                out_last_result
);
  import tcbst_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DISP = 4'd1;
  localparam logic [3:0] S_EM1  = 4'd2;
  localparam logic [3:0] S_EM2  = 4'd3;
  localparam logic [3:0] S_ENUM = 4'd4;
  localparam logic [3:0] S_EDIV = 4'd5;
  localparam logic [3:0] S_EM3  = 4'd6;
  localparam logic [3:0] S_EM4  = 4'd7;
  localparam logic [3:0] S_EFIN = 4'd8;
  localparam logic [3:0] S_WM1  = 4'd9;
  localparam logic [3:0] S_WM2  = 4'd10;
  localparam logic [3:0] S_WST  = 4'd11;
  localparam logic [3:0] S_MX1  = 4'd12;
  localparam logic [3:0] S_MX2  = 4'd13;
  localparam logic [3:0] S_MX3  = 4'd14;
  localparam logic [3:0] S_EMIT = 4'd15;

  logic [3:0]              st_r;
  cmd_t                    cmd_r;
  logic [NJOB-1:0]         pend_r, pend_left;
  logic [2:0]              job_r;
  logic [1:0]              ax_r, wi_r;
  logic                    ts_r, endl_r;
  logic [3:0][16:0]        w_r;
  logic signed [51:0]      prod_r, a_r, lo_r;
  logic [55:0]             dvd_r;
  logic [18:0]             rem_r, dd_r;
  logic                    neg_r;
  logic [5:0]              cnt_r;
  logic [2:0][39:0]        tin_r, tout_r;
  logic                    out_ld;

  // operand views
  logic signed [31:0] pp, pk, pc;
  logic signed [32:0] v10, v20, dp, dn;
  logic signed [16:0] f10r, f20r, f10, f20;
  logic signed [15:0] tsel;
  logic signed [17:0] m_s, tm, cm, cp, bm, bp, bsel, csel;
  logic [16:0]        w1, w2;
  logic signed [33:0] mul_a;
  logic signed [17:0] mul_b;

  // end tangent intermediates
  logic signed [53:0] num, numn;
  logic [16:0]        fabs;
  logic signed [55:0] n56;
  logic [18:0]        dd;
  logic [19:0]        rem_sh;
  logic               ge;
  logic signed [56:0] e_val;
  logic signed [79:0] acc80, mix80, rnd80;
  logic signed [52:0] msum;
  logic signed [51:0] wsum;
  logic [39:0]        tres;

  always_comb begin
    pp = $signed(cmd_r.p.pos[ax_r]);
    pk = $signed(cmd_r.k.pos[ax_r]);
    pc = $signed(cmd_r.c.pos[ax_r]);
    dp = {pk[31], pk} - {pp[31], pp};
    dn = {pc[31], pc} - {pk[31], pk};
    // end tangent differences, first or last key
    if (endl_r) begin
      v10  = dn;
      f10r = $signed({1'b0, cmd_r.c.frame}) - $signed({1'b0, cmd_r.k.frame});
      tsel = $signed(cmd_r.c.tcb[0]);
    end else begin
      v10  = dp;
      f10r = $signed({1'b0, cmd_r.k.frame}) - $signed({1'b0, cmd_r.p.frame});
      tsel = $signed(cmd_r.p.tcb[0]);
    end
    v20  = {pc[31], pc} - {pp[31], pp};
    f20r = $signed({1'b0, cmd_r.c.frame}) - $signed({1'b0, cmd_r.p.frame});
    if (f20r == 17'sd0) begin
      f10 = 17'sd0;
      f20 = 17'sd1;
    end else begin
      f10 = f10r;
      f20 = f20r;
    end
    m_s = Q14_ONE - {{2{tsel[15]}}, tsel};
    // interior weight factors
    tm = Q14_ONE - {{2{cmd_r.k.tcb[0][15]}}, cmd_r.k.tcb[0]};
    cm = Q14_ONE - {{2{cmd_r.k.tcb[1][15]}}, cmd_r.k.tcb[1]};
    cp = Q14_ONE + {{2{cmd_r.k.tcb[1][15]}}, cmd_r.k.tcb[1]};
    bm = Q14_ONE - {{2{cmd_r.k.tcb[2][15]}}, cmd_r.k.tcb[2]};
    bp = Q14_ONE + {{2{cmd_r.k.tcb[2][15]}}, cmd_r.k.tcb[2]};
    bsel = (wi_r == 2'd0 || wi_r == 2'd2) ? bp : bm;
    csel = (wi_r == 2'd0 || wi_r == 2'd3) ? cp : cm;
    w1 = ts_r ? w_r[2] : w_r[0];
    w2 = ts_r ? w_r[3] : w_r[1];
    e_val = neg_r ? -$signed({1'b0, dvd_r}) : $signed({1'b0, dvd_r});
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (st_r)
      S_EM1: begin
        mul_a = {v10[32], v10};
        mul_b = {f20[16], f20};
      end
      S_EM2: begin
        mul_a = {v20[32], v20};
        mul_b = {f10[16], f10};
      end
      S_EM3: begin
        mul_a = {8'd0, e_val[25:0]};
        mul_b = m_s;
      end
      S_EM4: begin
        mul_a = {{3{e_val[56]}}, e_val[56:26]};
        mul_b = m_s;
      end
      S_WM1: begin
        mul_a = {{16{tm[17]}}, tm};
        mul_b = bsel;
      end
      S_WM2: begin
        mul_a = prod_r[33:0];
        mul_b = csel;
      end
      S_MX1: begin
        mul_a = {dp[32], dp};
        mul_b = $signed({1'b0, w1});
      end
      S_MX2: begin
        mul_a = {dn[32], dn};
        mul_b = $signed({1'b0, w2});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // end tangent numerator, denominator and divider step
  always_comb begin
    num  = ({{2{a_r[51]}}, a_r} <<< 1) + {{2{a_r[51]}}, a_r} - {{2{prod_r[51]}}, prod_r};
    numn = f20[16] ? -num : num;
    fabs = f20[16] ? 17'(-f20) : 17'(f20);
    n56  = ({{2{numn[53]}}, numn} <<< 1) + $signed({38'd0, fabs, 1'b0});
    dd   = {fabs, 2'b00};
    rem_sh = {rem_r, dvd_r[55]};
    ge     = rem_sh >= {1'b0, dd_r};
    acc80 = ({{28{prod_r[51]}}, prod_r} <<< 26) + {{28{lo_r[51]}}, lo_r};
    msum  = {lo_r[51], lo_r} + {prod_r[51], prod_r};
    mix80 = {{27{msum[52]}}, msum};
    rnd80 = ((st_r == S_EFIN ? acc80 : mix80) + 80'sd8192) >>> 14;
    tres  = sat40(rnd80);
    wsum  = prod_r + 52'sd268435456;
  end

  assign q_pop  = (st_r == S_IDLE) && !q_empty;
  assign out_ld = (st_r == S_EMIT) && (!out_valid || !out_stall);

  always_comb begin
    pend_left = pend_r;
    pend_left[job_r] = 1'b0;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      case (st_r)
        S_IDLE: if (!q_empty) st_r <= S_DISP;
        S_DISP: begin
          if (pend_r[J_SH0] || pend_r[J_SH1] || pend_r[J_SH2]) begin
            st_r <= S_EMIT;
          end else if (pend_r[J_FIRST] || pend_r[J_FIN] && !pend_r[J_MID]) begin
            st_r <= S_EM1;
          end else begin
            st_r <= S_WM1;
          end
        end
        S_EM1:  st_r <= S_EM2;
        S_EM2:  st_r <= S_ENUM;
        S_ENUM: st_r <= S_EDIV;
        S_EDIV: if (cnt_r == 6'd55) st_r <= S_EM3;
        S_EM3:  st_r <= S_EM4;
        S_EM4:  st_r <= S_EFIN;
        S_EFIN: st_r <= (ax_r == 2'd2) ? S_EMIT : S_EM1;
        S_WM1:  st_r <= S_WM2;
        S_WM2:  st_r <= S_WST;
        S_WST:  st_r <= (wi_r == 2'd3) ? S_MX1 : S_WM1;
        S_MX1:  st_r <= S_MX2;
        S_MX2:  st_r <= S_MX3;
        S_MX3:  st_r <= (ax_r == 2'd2 && ts_r) ? S_EMIT : S_MX1;
        S_EMIT: if (out_ld) st_r <= (pend_left != '0) ? S_DISP : S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (st_r)
      S_IDLE: begin
        cmd_r  <= q_data;
        pend_r <= q_data.pend;
      end
      S_DISP: begin
        tin_r  <= '0;
        tout_r <= '0;
        ax_r   <= 2'd0;
        ts_r   <= 1'b0;
        wi_r   <= 2'd0;
        if (pend_r[J_SH0]) begin
          job_r <= J_SH0;
        end else if (pend_r[J_SH1]) begin
          job_r <= J_SH1;
        end else if (pend_r[J_SH2]) begin
          job_r <= J_SH2;
        end else if (pend_r[J_FIRST]) begin
          job_r  <= J_FIRST;
          endl_r <= 1'b0;
        end else if (pend_r[J_MID]) begin
          job_r <= J_MID;
        end else begin
          job_r  <= J_FIN;
          endl_r <= 1'b1;
        end
      end
      S_EM2: a_r <= prod_r;
      S_ENUM: begin
        dd_r  <= dd;
        rem_r <= '0;
        cnt_r <= '0;
        neg_r <= n56[55];
        if (n56[55]) begin
          dvd_r <= 56'(-n56 + $signed({37'd0, dd}) - 56'sd1);
        end else begin
          dvd_r <= n56;
        end
      end
      S_EDIV: begin
        rem_r <= ge ? 19'(rem_sh - {1'b0, dd_r}) : rem_sh[18:0];
        dvd_r <= {dvd_r[54:0], ge};
        cnt_r <= cnt_r + 6'd1;
      end
      S_EM4: lo_r <= prod_r;
      S_EFIN: begin
        if (endl_r) begin
          tin_r[ax_r] <= tres;
        end else begin
          tout_r[ax_r] <= tres;
        end
        ax_r <= ax_r + 2'd1;
      end
      S_WST: begin
        w_r[wi_r] <= wsum[45:29];
        wi_r      <= wi_r + 2'd1;
      end
      S_MX2: lo_r <= prod_r;
      S_MX3: begin
        if (ts_r) begin
          tout_r[ax_r] <= tres;
          ax_r         <= ax_r + 2'd1;
        end else begin
          tin_r[ax_r] <= tres;
        end
        ts_r <= ~ts_r;
      end
      S_EMIT: if (out_ld) pend_r <= pend_left;
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (out_ld) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ld) begin
      out_in_tan_x    <= tin_r[0];
      out_in_tan_y    <= tin_r[1];
      out_in_tan_z    <= tin_r[2];
      out_out_tan_x   <= tout_r[0];
      out_out_tan_y   <= tout_r[1];
      out_out_tan_z   <= tout_r[2];
      out_short_track <= (job_r == J_SH0) || (job_r == J_SH1) || (job_r == J_SH2);
      out_last_result <= (job_r == J_SH0) || (job_r == J_SH2) || (job_r == J_FIN);
      case (job_r)
        J_SH0, J_FIN: begin
          out_key_frame <= cmd_r.c.frame;
          out_x <= cmd_r.c.pos[0];
          out_y <= cmd_r.c.pos[1];
          out_z <= cmd_r.c.pos[2];
        end
        J_SH2: begin
          out_key_frame <= cmd_r.c.frame;
          out_x <= cmd_r.k.pos[0];
          out_y <= cmd_r.k.pos[1];
          out_z <= cmd_r.k.pos[2];
        end
        J_FIRST: begin
          out_key_frame <= cmd_r.p.frame;
          out_x <= cmd_r.p.pos[0];
          out_y <= cmd_r.p.pos[1];
          out_z <= cmd_r.p.pos[2];
        end
        default: begin
          out_key_frame <= cmd_r.k.frame;
          out_x <= cmd_r.k.pos[0];
          out_y <= cmd_r.k.pos[1];
          out_z <= cmd_r.k.pos[2];
        end
      endcase
    end
  end

endmodule

// ----- rtl/core/tcb_spline_tangents_top.sv -----
// top level of the tcb spline tangent generator
// Keys of one position track arrive in order, the last marked by in_last_key. The front end
// keeps a two key window and queues a command for each key that completes a result; the back
// end works it out with one shared 34x18 multiplier and a one bit per cycle divider. An
// interior key needs four weights and six tangent mixes. The first and last keys of a track
// each add an end tangent divide, done once per axis. Keys that complete no result queue
// no command; a two entry queue lets the front take keys while the back end works and a
// result waits in the output register.
module tcb_spline_tangents_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [15:0]         in_frame_number,
  input  logic signed [31:0]  in_pos_x,
  input  logic signed [31:0]  in_pos_y,
  input  logic signed [31:0]  in_pos_z,
  input  logic signed [15:0]  in_tension,
  input  logic signed [15:0]  in_continuity,
  input  logic signed [15:0]  in_bias,
  input  logic                in_last_key,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [15:0]         out_key_frame,
  output logic signed [31:0]  out_x,
  output logic signed [31:0]  out_y,
  output logic signed [31:0]  out_z,
  output logic signed [39:0]  out_in_tan_x,
  output logic signed [39:0]  out_in_tan_y,
  output logic signed [39:0]  out_in_tan_z,
  output logic signed [39:0]  out_out_tan_x,
  output logic signed [39:0]  out_out_tan_y,
  output logic signed [39:0]  out_out_tan_z,
  output logic                out_short_track,
  output logic                out_last_result
);
  import tcbst_pkg::*;

  cmd_t wr_cmd, rd_cmd;
  logic q_push, q_full, q_pop, q_empty;

  // key window and classification
  tcbst_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_frame_number, .in_pos_x, .in_pos_y,
    .in_pos_z, .in_tension, .in_continuity, .in_bias, .in_last_key,
    .q_full, .q_push, .q_data(wr_cmd)
  );

  // command queue
  tcbst_queue u_queue (
    .clk, .rst_n, .push(q_push), .wr_data(wr_cmd), .full(q_full),
    .pop(q_pop), .rd_data(rd_cmd), .empty(q_empty)
  );

  // tangent arithmetic and results
  tcbst_back u_back (
    .clk, .rst_n, .q_data(rd_cmd), .q_empty, .q_pop, .out_valid, .out_stall,
    .out_key_frame, .out_x, .out_y, .out_z, .out_in_tan_x, .out_in_tan_y,
    .out_in_tan_z, .out_out_tan_x, .out_out_tan_y, .out_out_tan_z,
    .out_short_track, .out_last_result
  );

endmodule

// ----- test/tcb_spline_tangents_top_tb.sv -----
// self-checking testbench for the tcb spline tangent generator
`timescale 1ns / 1ps

module tcb_spline_tangents_top_tb;
  import tcbst_pkg::*;

  localparam int  N_RANDOM_KEYS = 190;
  localparam int  CYCLE_LIMIT   = 1000000;
  localparam int  DRAIN_CYCLES  = 600;
  localparam int  HOLD_CYCLES   = 800;
  localparam longint Q14       = 16384;
  localparam longint TMAX      = 64'sd549755813887;
  localparam longint TMIN      = -64'sd549755813888;

  // one key as driven on the input channel
  typedef struct packed {
    logic [15:0]        frame;
    logic [2:0][31:0]   pos;
    logic [2:0][15:0]   tcb;
    logic               last;
  } key_item_t;

  // one tangent result as seen on the output channel
  typedef struct packed {
    logic [15:0]        frame;
    logic [2:0][31:0]   pos;
    logic [2:0][39:0]   tin;
    logic [2:0][39:0]   tout;
    logic               shrt;
    logic               last;
  } tan_res_t;

  // one directed row, with a typed result where it is obvious
  typedef struct packed {
    key_item_t key;
    logic      typed;
    tan_res_t  res;
  } key_row_t;

  // key as held in the prediction window
  typedef struct {
    longint frame;
    longint pos[3];
    longint tcb[3];
  } win_key_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [15:0] in_frame_number = '0;
  logic signed [31:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic signed [15:0] in_tension = '0, in_continuity = '0, in_bias = '0;
  logic in_last_key = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [15:0] out_key_frame;
  logic signed [31:0] out_x, out_y, out_z;
  logic signed [39:0] out_in_tan_x, out_in_tan_y, out_in_tan_z;
  logic signed [39:0] out_out_tan_x, out_out_tan_y, out_out_tan_z;
  logic out_short_track, out_last_result;

  tcb_spline_tangents_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_frame_number(in_frame_number),
    .in_pos_x(in_pos_x), .in_pos_y(in_pos_y), .in_pos_z(in_pos_z),
    .in_tension(in_tension), .in_continuity(in_continuity), .in_bias(in_bias),
    .in_last_key(in_last_key),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_key_frame(out_key_frame),
    .out_x(out_x), .out_y(out_y), .out_z(out_z),
    .out_in_tan_x(out_in_tan_x), .out_in_tan_y(out_in_tan_y),
    .out_in_tan_z(out_in_tan_z),
    .out_out_tan_x(out_out_tan_x), .out_out_tan_y(out_out_tan_y),
    .out_out_tan_z(out_out_tan_z),
    .out_short_track(out_short_track), .out_last_result(out_last_result)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  tan_res_t  expected_tangents[$];
  key_row_t  directed_rows[$];
  int        key_count;
  win_key_t  older_key, middle_key;
  int        mismatches = 0;
  int        results_seen = 0;
  int        keys_sent = 0;
  int        tracks_sent = 0;
  int        cycles = 0;
  int        idle_pct = 0;
  int        stall_pct = 0;
  bit        hold_off = 1'b0;

  // tension, continuity and bias saturate to -1..1
  function automatic longint clamp_unit(logic signed [15:0] v);
    if (v > 16384) return Q14;
    if (v < -16384) return -Q14;
    return longint'(v);
  endfunction

  function automatic longint sat_tan(longint v);
    if (v > TMAX) return TMAX;
    if (v < TMIN) return TMIN;
    return v;
  endfunction

  function automatic longint floor_quot(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q = q - 1;
    return q;
  endfunction

  // q14 weight (1-t)(1+-b)(1+-c)/2, rounded half up
  function automatic longint tcb_weight(longint tm, longint bf, longint cf);
    longint p;
    p = tm * bf * cf;
    return (p + (longint'(1) <<< 28)) >>> 29;
  endfunction

  function automatic longint blend(longint w1, longint d1, longint w2, longint d2);
    return sat_tan((w1 * d1 + w2 * d2 + 8192) >>> 14);
  endfunction

  // end tangent (1-T)(1.5*v10 - v20*f10/(2*f20))
  function automatic longint end_tangent(longint v10, longint v20, longint f10,
                                         longint f20, longint t);
    longint num, den, e, eh, el, m;
    if (f20 == 0) begin
      f10 = 0;
      f20 = 1;
    end
    num = 3 * v10 * f20 - v20 * f10;
    den = 2 * f20;
    if (den < 0) begin
      num = -num;
      den = -den;
    end
    e = floor_quot(2 * num + den, 2 * den);
    m = Q14 - t;
    eh = e >>> 14;
    el = e - eh * Q14;
    return sat_tan(eh * m + ((el * m + 8192) >>> 14));
  endfunction

  function automatic tan_res_t make_res(longint frame, longint pos[3], longint tin[3],
                                        longint tout[3], bit shrt, bit last);
    tan_res_t r;
    r.frame = frame[15:0];
    for (int i = 0; i < 3; i++) begin
      r.pos[i] = pos[i][31:0];
      r.tin[i] = tin[i][39:0];
      r.tout[i] = tout[i][39:0];
    end
    r.shrt = shrt;
    r.last = last;
    return r;
  endfunction

  // advance the key window by one key and queue the tangents it completes
  task automatic predict_tangents(key_item_t it, ref tan_res_t res[$]);
    win_key_t cur;
    longint zero[3], ta[3], tb[3];
    longint tm, cm, cp, bm, bp, wa, wb, wc, wd, dp, dn;
    cur.frame = it.frame;
    zero = '{0, 0, 0};
    for (int i = 0; i < 3; i++) begin
      cur.pos[i] = longint'($signed(it.pos[i]));
      cur.tcb[i] = clamp_unit($signed(it.tcb[i]));
    end
    if (key_count == 0) begin
      if (it.last) begin
        res.push_back(make_res(cur.frame, cur.pos, zero, zero, 1, 1));
        return;
      end
    end else if (key_count == 1) begin
      if (it.last) begin
        res.push_back(make_res(middle_key.frame, middle_key.pos, zero, zero, 1, 0));
        res.push_back(make_res(cur.frame, middle_key.pos, zero, zero, 1, 1));
        key_count = 0;
        return;
      end
    end else begin
      if (key_count == 2) begin
        for (int i = 0; i < 3; i++)
          tb[i] = end_tangent(middle_key.pos[i] - older_key.pos[i],
                              cur.pos[i] - older_key.pos[i],
                              middle_key.frame - older_key.frame,
                              cur.frame - older_key.frame, older_key.tcb[0]);
        res.push_back(make_res(older_key.frame, older_key.pos, zero, tb, 0, 0));
      end
      tm = Q14 - middle_key.tcb[0];
      cm = Q14 - middle_key.tcb[1];
      cp = Q14 + middle_key.tcb[1];
      bm = Q14 - middle_key.tcb[2];
      bp = Q14 + middle_key.tcb[2];
      wa = tcb_weight(tm, bp, cp);
      wb = tcb_weight(tm, bm, cm);
      wc = tcb_weight(tm, bp, cm);
      wd = tcb_weight(tm, bm, cp);
      for (int i = 0; i < 3; i++) begin
        dp = middle_key.pos[i] - older_key.pos[i];
        dn = cur.pos[i] - middle_key.pos[i];
        ta[i] = blend(wa, dp, wb, dn);
        tb[i] = blend(wc, dp, wd, dn);
      end
      res.push_back(make_res(middle_key.frame, middle_key.pos, ta, tb, 0, 0));
      if (it.last) begin
        for (int i = 0; i < 3; i++)
          ta[i] = end_tangent(cur.pos[i] - middle_key.pos[i],
                              cur.pos[i] - older_key.pos[i],
                              cur.frame - middle_key.frame,
                              cur.frame - older_key.frame, cur.tcb[0]);
        res.push_back(make_res(cur.frame, cur.pos, ta, zero, 0, 1));
        key_count = 0;
        return;
      end
    end
    older_key = middle_key;
    middle_key = cur;
    if (key_count < 65535) key_count++;
  endtask

  function automatic key_item_t mk_key(int frame, logic [31:0] x, logic [31:0] y,
                                       logic [31:0] z, logic [15:0] t, logic [15:0] c,
                                       logic [15:0] b, bit last);
    key_item_t k;
    k.frame = frame[15:0];
    k.pos = {z, y, x};
    k.tcb = {b, c, t};
    k.last = last;
    return k;
  endfunction

  function automatic key_item_t rand_key(int frame, bit wide, bit last);
    key_item_t k;
    k.frame = frame[15:0];
    for (int i = 0; i < 3; i++) begin
      k.pos[i] = wide ? $urandom : 32'($signed($urandom_range(2097152)) - 1048576);
      k.tcb[i] = ($urandom_range(9) < 8) ? 16'($signed($urandom_range(32768)) - 16384)
                                          : 16'($urandom);
    end
    k.last = last;
    return k;
  endfunction

  // drive one key and wait for it to be taken
  task automatic send_key(key_item_t k, bit typed, tan_res_t typed_res);
    tan_res_t res[$];
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_frame_number <= k.frame;
    in_pos_x <= k.pos[0];
    in_pos_y <= k.pos[1];
    in_pos_z <= k.pos[2];
    in_tension <= k.tcb[0];
    in_continuity <= k.tcb[1];
    in_bias <= k.tcb[2];
    in_last_key <= k.last;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    predict_tangents(k, res);
    if (typed) res = '{typed_res};
    foreach (res[i]) expected_tangents.push_back(res[i]);
    keys_sent++;
    if (k.last) tracks_sent++;
    @(negedge clk);
  endtask

  task automatic check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %0s: expected %0d actual %0d (result %0d)",
                 name, exp_v, act_v, results_seen);
    end
  endtask

  // compare each taken result with the oldest expectation
  always @(posedge clk) begin
    tan_res_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_tangents.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result, frame %0d", out_key_frame);
      end else begin
        e = expected_tangents.pop_front();
        check_field("key_frame", e.frame, out_key_frame);
        check_field("x", $signed(e.pos[0]), out_x);
        check_field("y", $signed(e.pos[1]), out_y);
        check_field("z", $signed(e.pos[2]), out_z);
        check_field("in_tan_x", $signed(e.tin[0]), out_in_tan_x);
        check_field("in_tan_y", $signed(e.tin[1]), out_in_tan_y);
        check_field("in_tan_z", $signed(e.tin[2]), out_in_tan_z);
        check_field("out_tan_x", $signed(e.tout[0]), out_out_tan_x);
        check_field("out_tan_y", $signed(e.tout[1]), out_out_tan_y);
        check_field("out_tan_z", $signed(e.tout[2]), out_out_tan_z);
        check_field("short_track", e.shrt, out_short_track);
        check_field("last_result", e.last, out_last_result);
      end
      results_seen++;
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    out_stall <= hold_off || ($urandom_range(99) < stall_pct);
  end

  // long receiver hold-off while keys keep coming
  initial begin
    wait (keys_sent >= 120);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    key_row_t row;
    tan_res_t none;
    int frame, len, n;
    none = '0;

    // directed keys
    row = '0;
    row.key = mk_key(65535, 32'h7fffffff, 32'h80000000, 0, 16'sd16384, -16'sd16384, 0, 1);
    row.typed = 1'b1;
    row.res.frame = 16'hffff;
    row.res.pos = {32'h0, 32'h80000000, 32'h7fffffff};
    row.res.shrt = 1'b1;
    row.res.last = 1'b1;
    directed_rows.push_back(row);
    row = '0;
    row.key = mk_key(0, 0, 32'hffffffff, 32'h00010000, 0, 0, 0, 1);
    row.typed = 1'b1;
    row.res.pos = {32'h00010000, 32'hffffffff, 32'h0};
    row.res.shrt = 1'b1;
    row.res.last = 1'b1;
    directed_rows.push_back(row);
    // two key short track
    row = '0;
    row.key = mk_key(10, 32'h00050000, 32'hfffb0000, 7, 100, 200, 300, 0);
    directed_rows.push_back(row);
    row.key = mk_key(20, 32'h12345678, 32'h0, 9, 0, 0, 0, 1);
    directed_rows.push_back(row);
    // plain three key track
    row.key = mk_key(0, 0, 0, 0, 0, 0, 0, 0);
    directed_rows.push_back(row);
    row.key = mk_key(10, 32'h000a0000, 32'h00140000, 32'hfff60000, 0, 0, 0, 0);
    directed_rows.push_back(row);
    row.key = mk_key(30, 32'h00320000, 32'h0, 32'h00010000, 0, 0, 0, 1);
    directed_rows.push_back(row);
    // tcb extremes and out of range values, full scale positions
    row.key = mk_key(100, 32'h80000000, 32'h7fffffff, 32'h80000000,
                     -16'sd16384, 16'sd16384, -16'sd16384, 0);
    directed_rows.push_back(row);
    row.key = mk_key(101, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                     -16'sd32768, 16'sh7fff, 16'sh7fff, 0);
    directed_rows.push_back(row);
    row.key = mk_key(102, 32'h80000000, 32'h7fffffff, 32'h80000000,
                     -16'sd16384, -16'sd32768, 16'sd16384, 0);
    directed_rows.push_back(row);
    row.key = mk_key(65535, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                     -16'sd20000, 16'sd16384, -16'sd16384, 1);
    directed_rows.push_back(row);
    // equal frames: the far frame difference is zero
    row.key = mk_key(50, 32'h00100000, 32'h00200000, 32'h00300000, 16'sd8192, 0, 0, 0);
    directed_rows.push_back(row);
    row.key = mk_key(50, 32'h00200000, 32'h00100000, 32'h0, 16'sd4096, 16'sd4096, 0, 0);
    directed_rows.push_back(row);
    row.key = mk_key(50, 32'h00300000, 32'h00500000, 32'hffff0000, 0, 0, 16'sd8192, 1);
    directed_rows.push_back(row);
    // disordered frames, five keys
    row.key = mk_key(900, 32'h01000000, 32'h0, 32'h00008000, 16'sd1000, -16'sd3000, 16'sd77, 0);
    directed_rows.push_back(row);
    row.key = mk_key(300, 32'hff000000, 32'h00001234, 32'h0, -16'sd5000, 16'sd2000, 0, 0);
    directed_rows.push_back(row);
    row.key = mk_key(600, 32'h00000001, 32'h7fff0000, 32'h8000ffff, 0, 16'sd16000, 16'sd3, 0);
    directed_rows.push_back(row);
    row.key = mk_key(1, 32'h00400000, 32'h80010000, 32'h00020000, 16'sd16383, 0, -16'sd1, 0);
    directed_rows.push_back(row);
    row.key = mk_key(0, 32'hfffffffe, 32'h00000003, 32'h7ffffff0, -16'sd1, 16'sd1, 16'sd1, 1);
    directed_rows.push_back(row);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    key_count = 0;
    older_key = '{0, '{0, 0, 0}, '{0, 0, 0}};
    middle_key = older_key;
    @(negedge clk);

    foreach (directed_rows[i])
      send_key(directed_rows[i].key, directed_rows[i].typed, directed_rows[i].res);

    // random tracks, idling pattern changing by phase
    n = 0;
    while (n < N_RANDOM_KEYS) begin
      case ((n / 53) % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 52; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 52; end
        default: begin idle_pct = 28; stall_pct = 28; end
      endcase
      len = ($urandom_range(99) < 15) ? $urandom_range(1, 2) : $urandom_range(3, 8);
      frame = $urandom_range(65535);
      for (int k = 0; k < len; k++) begin
        send_key(rand_key(frame, $urandom_range(3) == 0, k == len - 1), 1'b0, none);
        frame = ($urandom_range(99) < 85) ? frame + $urandom_range(1, 200)
                                          : $urandom_range(65535);
        n++;
      end
    end
    in_valid <= 1'b0;
    idle_pct = 0;
    stall_pct = 0;

    wait (expected_tangents.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d keys in %0d tracks, %0d results checked, %0d mismatches",
             keys_sent, tracks_sent, results_seen, mismatches);
    $display("covered short tracks, tcb extremes, equal and disordered frames, saturation");
    if (mismatches == 0 && expected_tangents.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
